### rtl/ddpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddpd_pkg: shared constants, types and helpers of the pose delta pipeline
// Fixed-point constants, the arctangent table, the CORDIC gain and the
// per-stage payload type.
// ----------------------------------------------------------------------------
package ddpd_pkg;

  // CORDIC depth; the arctangent table holds ROM_SIZE entries
  localparam int CORDIC_STAGES = 16;
  localparam int ROM_SIZE      = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > ROM_SIZE) ? ROM_SIZE : CORDIC_STAGES;

  // Configuration port
  localparam int          PADDR_W         = 2;
  localparam logic [PADDR_W-1:0] ADDR_STEP_TIME = 2'd0;
  localparam logic [15:0] STEP_TIME_RESET = 16'd6554;

  // Stream widths
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 96;

  // Angles in Q.30
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  // round(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_ROM [ROM_SIZE] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Inverse CORDIC gain in Q.30 for n stages: round(2^60 / isqrt(prod(1 + 4^-i) in Q60)).
  // Elaboration only; shift-and-subtract square root and long division.
  function automatic logic [63:0] gain_inv_q30(input int n);
    logic [63:0] prod;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    prod = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      prod = prod + (prod >> (2 * i));
    end
    v   = prod;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    num = (64'd1 << 60) + (res >> 1);
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= res) begin
        rem  = rem - res;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic signed [31:0] GAIN_INV_Q30 = 32'(gain_inv_q30(CORDIC_N));

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Payload carried through the CORDIC stages
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [33:0] z;
    logic signed [31:0] vdt;
    logic               flip;
    logic signed [31:0] heading;
  } cordic_t;

endpackage
`default_nettype wire

### rtl/diff_drive_pose_delta_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_pose_delta_top: midpoint odometry step of a differential drive
// Per sample (speed, turn_rate) returns v*dt*cos(w*dt/2), v*dt*sin(w*dt/2)
// and w*dt in Q8.24, cos/sin from a pipelined rotation-mode CORDIC.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    payload
//  s_*       in   s_tvalid / s_tready          s_tdata: speed, turn_rate
//  m_*       out  m_tvalid / m_tready          m_tdata: delta_x, delta_y, delta_heading
//  p*        in   psel/penable/pwrite, pready  step_time at byte address 0
//
//  Throughput: one request per cycle while m_tready keeps the output moving.
//  Registers in order: multiply, fold, one per CORDIC stage, sign fix, multiply, output.
//  Each stage has its own valid bit and loads when it is empty or the stage
//  after it moves, so a stalled output holds and bubbles close up behind it.
//  Reset (rst, synchronous) clears all valid bits and restores step_time.
//
module diff_drive_pose_delta_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  // [15:0] speed, [31:16] turn_rate
  input  wire logic [ddpd_pkg::TDATA_IN_W-1:0]  s_tdata,
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] delta_x, [63:32] delta_y, [95:64] delta_heading
  output      logic [ddpd_pkg::TDATA_OUT_W-1:0] m_tdata,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ddpd_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output      logic [31:0]                     prdata,
  output      logic                            pready
);
  import ddpd_pkg::*;

  // ---------------- configuration ----------------
  logic [15:0] step_time;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STEP_TIME) ? {16'd0, step_time} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_TIME_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_STEP_TIME)) begin
      step_time <= pwdata[15:0];
    end
  end

  // ---------------- stage enables (ready chain) ----------------
  logic en_p1;
  logic en_c [CORDIC_N+1];
  logic en_neg;
  logic en_mul;
  logic en_out;

  logic    p1_valid;
  logic    cv  [CORDIC_N+1];
  cordic_t cst [CORDIC_N+1];
  logic    neg_valid;
  logic    mul_valid;

  assign en_out       = !m_tvalid || m_tready;
  assign en_mul       = !mul_valid || en_out;
  assign en_neg       = !neg_valid || en_mul;
  assign en_c[CORDIC_N] = !cv[CORDIC_N] || en_neg;
  for (genvar k = 0; k < CORDIC_N; k++) begin : g_en
    assign en_c[k] = !cv[k] || en_c[k+1];
  end
  assign en_p1    = !p1_valid || en_c[0];
  assign s_tready = en_p1;

  // ---------------- stage 1: v*dt, w*dt (Q4.28) ----------------
  logic signed [15:0] in_speed;
  logic signed [15:0] in_turn;
  logic signed [16:0] dt_s;
  logic signed [31:0] vdt_c;
  logic signed [31:0] turn_c;
  logic signed [31:0] p1_vdt;
  logic signed [31:0] p1_turn;

  assign in_speed = s_tdata[15:0];
  assign in_turn  = s_tdata[31:16];
  assign dt_s     = {1'b0, step_time};
  assign vdt_c    = in_speed * dt_s;    // always fits 32 bits
  assign turn_c   = in_turn * dt_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en_p1) begin
      p1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p1) begin
      p1_vdt  <= vdt_c;
      p1_turn <= turn_c;
    end
  end

  // ---------------- stage 2: half angle, quadrant fold, heading ----------------
  logic signed [33:0] z_half;
  logic signed [32:0] h_sum;
  cordic_t            fold_c;

  assign z_half = {p1_turn[31], p1_turn, 1'b0};   // turn * 2 -> Q.30
  assign h_sum  = {p1_turn[31], p1_turn} + 33'sd8;

  always_comb begin
    fold_c.x       = GAIN_INV_Q30;
    fold_c.y       = '0;
    fold_c.vdt     = p1_vdt;
    fold_c.heading = sat32($signed({{31{h_sum[32]}}, h_sum}) >>> 4);
    fold_c.flip    = 1'b0;
    fold_c.z       = z_half;
    if (z_half > HALF_PI_Q30) begin
      fold_c.z    = z_half - PI_Q30;
      fold_c.flip = 1'b1;
    end else if (z_half < -HALF_PI_Q30) begin
      fold_c.z    = z_half + PI_Q30;
      fold_c.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en_c[0]) begin
      cv[0] <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c[0]) begin
      cst[0] <= fold_c;
    end
  end

  // ---------------- CORDIC rotation stages ----------------
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
    logic signed [31:0] xi;
    logic signed [31:0] yi;
    logic signed [33:0] ai;
    cordic_t            nxt;

    assign xi = cst[i].x;
    assign yi = cst[i].y;
    assign ai = {2'b00, ATAN_ROM[i]};

    always_comb begin
      nxt = cst[i];
      if (!cst[i].z[33]) begin
        nxt.x = xi - (yi >>> i);
        nxt.y = yi + (xi >>> i);
        nxt.z = cst[i].z - ai;
      end else begin
        nxt.x = xi + (yi >>> i);
        nxt.y = yi - (xi >>> i);
        nxt.z = cst[i].z + ai;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en_c[i+1]) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en_c[i+1]) begin
        cst[i+1] <= nxt;
      end
    end
  end

  // ---------------- sign fix for folded angles ----------------
  logic signed [31:0] neg_x;
  logic signed [31:0] neg_y;
  logic signed [31:0] neg_vdt;
  logic signed [31:0] neg_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_valid <= 1'b0;
    end else if (en_neg) begin
      neg_valid <= cv[CORDIC_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en_neg) begin
      neg_x       <= cst[CORDIC_N].flip ? -cst[CORDIC_N].x : cst[CORDIC_N].x;
      neg_y       <= cst[CORDIC_N].flip ? -cst[CORDIC_N].y : cst[CORDIC_N].y;
      neg_vdt     <= cst[CORDIC_N].vdt;
      neg_heading <= cst[CORDIC_N].heading;
    end
  end

  // ---------------- v*dt times cos / sin ----------------
  logic signed [63:0] px_c;
  logic signed [63:0] py_c;
  logic signed [63:0] mul_px;
  logic signed [63:0] mul_py;
  logic signed [31:0] mul_heading;

  assign px_c = neg_vdt * neg_x;
  assign py_c = neg_vdt * neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en_mul) begin
      mul_valid <= neg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      mul_px      <= px_c;
      mul_py      <= py_c;
      mul_heading <= neg_heading;
    end
  end

  // ---------------- round to Q8.24, saturate, output register ----------------
  localparam logic signed [63:0] RND_HALF = 64'sd8589934592;   // 2^33
  logic signed [63:0] rx;
  logic signed [63:0] ry;

  assign rx = (mul_px + RND_HALF) >>> 34;
  assign ry = (mul_py + RND_HALF) >>> 34;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= {mul_heading, sat32(ry), sat32(rx)};
    end
  end

endmodule
`default_nettype wire

### tb/pose_delta_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pose_delta_checker: scoreboard for the pose delta pipeline
// Watches the sample, result and register channels. It predicts each pose
// delta with its own CORDIC model and compares the results in order.
// ----------------------------------------------------------------------------
module pose_delta_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  input  wire logic                                s_tready,
  // [15:0] speed, [31:16] turn_rate
  input  wire logic [ddpd_pkg::TDATA_IN_W-1:0]     s_tdata,
  input  wire logic                                m_tvalid,
  input  wire logic                                m_tready,
  // [31:0] delta_x, [63:32] delta_y, [95:64] delta_heading
  input  wire logic [ddpd_pkg::TDATA_OUT_W-1:0]    m_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ddpd_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                         pwdata,
  input  wire logic [31:0]                         prdata,
  input  wire logic                                pready,
  output int                                       mismatches,
  output int                                       outstanding
);

  localparam int     ATAN_DEPTH   = 24;
  localparam int     STAGES       = (ddpd_pkg::CORDIC_STAGES > ATAN_DEPTH) ?
                                    ATAN_DEPTH : ddpd_pkg::CORDIC_STAGES;
  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint QTR_PI_Q30   = 64'sd843314857;
  localparam longint HALF_LSB_S34 = 64'sd8589934592;
  localparam longint HALF_LSB_S4  = 64'sd8;
  localparam longint S32_TOP      = 64'sd2147483647;
  localparam longint S32_BOTTOM   = -64'sd2147483648;

  // Same bit order as m_tdata
  typedef struct packed {
    logic signed [31:0] heading;
    logic signed [31:0] dy;
    logic signed [31:0] dx;
  } pose_delta_t;

  longint      atan_q30 [ATAN_DEPTH];
  longint      gain_inv_q30;
  logic [15:0] step_time;
  pose_delta_t pose_q [$];
  logic [31:0] sample_q [$];

  // atan(2^-i) in Q.30 from the alternating arctangent series (pi/4 for i = 0)
  function automatic longint atan_entry(input int i);
    longint unsigned acc;
    longint unsigned term;
    bit              add;
    acc = 0;
    add = 1'b1;
    if (i == 0) begin
      return QTR_PI_Q30;
    end
    for (int k = 1; i * k <= 60; k += 2) begin
      term = (64'd1 << (60 - i * k)) / longint'(k);
      acc  = add ? acc + term : acc - term;
      add  = !add;
    end
    return longint'((acc + (64'd1 << 29)) >> 30);
  endfunction

  // 1 / prod sqrt(1 + 4^-i), Q.30, rounded
  function automatic longint cordic_gain_inv(input int n);
    longint unsigned sq;
    longint unsigned root;
    longint unsigned bitv;
    sq   = 64'd1 << 60;
    root = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < n; i++) begin
      sq = sq + (sq >> (2 * i));
    end
    while (bitv > sq) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (sq >= root + bitv) begin
        sq   = sq - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(((64'd1 << 60) + (root >> 1)) / root);
  endfunction

  function automatic logic signed [31:0] clamp_s32(input longint v);
    longint c;
    c = (v > S32_TOP) ? S32_TOP : ((v < S32_BOTTOM) ? S32_BOTTOM : v);
    return c[31:0];
  endfunction

  function automatic pose_delta_t predict_pose_delta(input logic signed [15:0] speed,
                                                     input logic signed [15:0] turn_rate,
                                                     input logic [15:0] dt);
    pose_delta_t r;
    longint      v;
    longint      w;
    longint      d;
    longint      turn;
    longint      vdt;
    longint      z;
    longint      x;
    longint      y;
    longint      nx;
    bit          flip;
    v    = speed;
    w    = turn_rate;
    d    = longint'(dt);
    turn = w * d;
    vdt  = v * d;
    z    = turn * 2;
    flip = 1'b0;
    // fold the half angle into [-pi/2, pi/2]
    if (z > HALF_PI_Q30) begin
      z    = z - PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z    = z + PI_Q30;
      flip = 1'b1;
    end
    x = gain_inv_q30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_q30[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.dx      = clamp_s32((vdt * x + HALF_LSB_S34) >>> 34);
    r.dy      = clamp_s32((vdt * y + HALF_LSB_S34) >>> 34);
    r.heading = clamp_s32((turn + HALF_LSB_S4) >>> 4);
    return r;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    step_time   = ddpd_pkg::STEP_TIME_RESET;
    for (int i = 0; i < ATAN_DEPTH; i++) begin
      atan_q30[i] = atan_entry(i);
    end
    gain_inv_q30 = cordic_gain_inv(STAGES);
  end

  always @(posedge clk) begin
    pose_delta_t want;
    pose_delta_t got;
    logic [31:0] req;
    if (rst) begin
      step_time = ddpd_pkg::STEP_TIME_RESET;
      pose_q.delete();
      sample_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pose_q.push_back(predict_pose_delta(s_tdata[15:0], s_tdata[31:16], step_time));
        sample_q.push_back(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got = pose_delta_t'(m_tdata);
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result x=%0d y=%0d h=%0d", got.dx, got.dy, got.heading);
          end
        end else begin
          want = pose_q.pop_front();
          req  = sample_q.pop_front();
          if (got.dx !== want.dx || got.dy !== want.dy || got.heading !== want.heading) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch speed=%0d turn=%0d: exp x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                       $signed(req[15:0]), $signed(req[31:16]),
                       want.dx, want.dy, want.heading, got.dx, got.dy, got.heading);
            end
          end
        end
      end
      // register access completes on the access cycle
      if (psel && penable && pready && paddr == ddpd_pkg::ADDR_STEP_TIME) begin
        if (pwrite) begin
          step_time = pwdata[15:0];
        end else if (prdata !== {16'd0, step_time}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("step_time readback: exp %0d, got %0d", step_time, prdata);
          end
        end
      end
    end
    outstanding = pose_q.size();
  end

endmodule
`default_nettype wire

### tb/tb_diff_drive_pose_delta_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_diff_drive_pose_delta_top: stream test of the pose delta pipeline
// Directed corner samples, then random samples over several step times and
// flow-control patterns; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_diff_drive_pose_delta_top;

  localparam int  ITEMS_PER_PHASE = 116;
  localparam int  PHASES          = 8;
  localparam int  HOLD_CYCLES     = 400;
  // pipeline depth plus a little slack
  localparam int  DRAIN_CYCLES    = ddpd_pkg::CORDIC_N + 9;
  localparam int  CYCLE_LIMIT     = 400000;
  localparam logic [ddpd_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 2'd1;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  // [15:0] speed, [31:16] turn_rate
  logic [ddpd_pkg::TDATA_IN_W-1:0]  s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  // [31:0] delta_x, [63:32] delta_y, [95:64] delta_heading
  logic [ddpd_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [ddpd_pkg::PADDR_W-1:0]     paddr;
  logic [31:0]                      pwdata;
  logic [31:0]                      prdata;
  logic                             pready;

  int mismatches;
  int outstanding;
  int cycles;

  // flow-control knobs, percent of cycles
  int idle_pct;
  int stall_pct;
  // long receiver hold-off; raised by the stimulus, cleared by the receiver
  bit hold_req;
  int hold_cnt;

  diff_drive_pose_delta_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pose_delta_checker u_pose_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Watchdog
  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[diff_drive_pose_delta_top] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off when asked.
  initial begin
    m_tready <= 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Q4.12 field value, biased toward the ends of the range and near zero
  function automatic logic [15:0] pick_q412();
    logic [15:0] r;
    case ($urandom_range(0, 9))
      0:       r = 16'h7FFF;
      1:       r = 16'h8000;
      2:       r = 16'($urandom_range(0, 31)) - 16'd16;
      default: r = 16'($urandom);
    endcase
    return r;
  endfunction

  // One sample request; returns at the edge that takes it, then maybe idles.
  task automatic push_sample(input logic [15:0] speed, input logic [15:0] turn_rate);
    s_tdata  <= {turn_rate, speed};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every result is back and the pipe is empty.
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup phase, access phase until pready, then back to idle
  task automatic reg_access(input logic wr, input logic [ddpd_pkg::PADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Set dt (junk in the upper half of the bus) and read it back.
  task automatic set_step_time(input logic [15:0] dt);
    reg_access(1'b1, ddpd_pkg::ADDR_STEP_TIME, {16'($urandom), dt});
    reg_access(1'b0, ddpd_pkg::ADDR_STEP_TIME, 32'd0);
  endtask

  initial begin
    logic [15:0] dt;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of dt, readback only
    reg_access(1'b0, ddpd_pkg::ADDR_STEP_TIME, 32'd0);

    // Directed, reset dt (about 0.1 s): field extremes and sign mixes
    push_sample(16'h0000, 16'h0000);
    push_sample(16'h7FFF, 16'h7FFF);
    push_sample(16'h8000, 16'h8000);
    push_sample(16'h7FFF, 16'h8000);
    push_sample(16'h8000, 16'h7FFF);
    push_sample(16'h0001, 16'hFFFF);
    push_sample(16'hFFFF, 16'h0001);
    drain_pipe();

    // Largest dt: half angle crosses +-pi/2 near |w| = 12868, so both folds
    set_step_time(16'hFFFF);
    push_sample(16'h7FFF, 16'd12868);
    push_sample(16'h7FFF, 16'd12869);
    push_sample(16'h8000, -16'sd12868);
    push_sample(16'h8000, -16'sd12869);
    push_sample(16'h7FFF, 16'h7FFF);
    push_sample(16'h7FFF, 16'h8000);
    push_sample(16'h8000, 16'h8000);
    push_sample(16'h1000, 16'h0000);
    push_sample(16'h0001, 16'h0001);
    drain_pipe();

    // Zero step time: every output zero
    set_step_time(16'h0000);
    push_sample(16'h7FFF, 16'h7FFF);
    push_sample(16'h8000, 16'h8000);
    push_sample(16'd1234, -16'sd4321);
    drain_pipe();

    // Write to an unmapped address must leave dt at zero
    reg_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF);
    reg_access(1'b0, ddpd_pkg::ADDR_STEP_TIME, 32'd0);
    push_sample(16'h7FFF, 16'h7FFF);
    push_sample(16'h4000, 16'hC000);
    drain_pipe();

    // Random phases: dt setting and flow-control pattern change per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       dt = 16'hFFFF;
        1:       dt = 16'd1;
        2:       dt = 16'h8000;
        4:       dt = ddpd_pkg::STEP_TIME_RESET;
        5:       dt = 16'($urandom_range(1, 4096));
        6:       dt = 16'hFFFE;
        default: dt = 16'($urandom);
      endcase
      set_step_time(dt);
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 68;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 68;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      // back-to-back requests against a stopped output: pipe fills, s_tready drops
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender pause mid-phase until all results are back
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) begin
          drain_pipe();
        end
        push_sample(pick_q412(), pick_q412());
      end
      drain_pipe();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("[diff_drive_pose_delta_top] OK");
    end else begin
      $display("[diff_drive_pose_delta_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### diff_drive_pose_delta_top.f
rtl/ddpd_pkg.sv
rtl/diff_drive_pose_delta_top.sv
tb/pose_delta_checker.sv
tb/tb_diff_drive_pose_delta_top.sv
